// File: hw/rtl/lfgd_pkg.sv
// Shared types and constants for the LZSS flag-group decoder.
// Depends on nothing; the top level and the core refer to it by scoped names.
`timescale 1ns / 1ps
package lfgd_pkg;

	// input transaction: one byte of the compressed file
	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_of_stream;
	} in_t;

	// output transaction: one result
	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] status;
		logic       last_of_run;
	} out_t;

	// result handed from the core to the output register
	typedef struct packed {
		logic valid;
		out_t res;
	} emit_t;

	// result status codes
	localparam logic [2:0] STAT_BYTE      = 3'd0;
	localparam logic [2:0] STAT_FINAL     = 3'd1;
	localparam logic [2:0] STAT_BAD_MAGIC = 3'd2;
	localparam logic [2:0] STAT_EMPTY     = 3'd3;
	localparam logic [2:0] STAT_BAD_DIST  = 3'd4;

	// header layout: signature bytes, then a little-endian 32-bit size
	localparam logic [3:0] SIG_LEN  = 4'd8;
	localparam logic [3:0] HDR_LAST = 4'd11;
	localparam logic [7:0] SIG_BYTES [8] = '{
		8'h4C, 8'h5A, 8'h30, 8'h1A, 8'h00, 8'h77, 8'h00, 8'h01
	};

	// back-reference coding
	localparam int unsigned DIST_W         = 13;
	localparam logic [4:0]  MATCH_LEN_BASE = 5'd3;

endpackage

// File: hw/rtl/lz77_flag_group_decoder_top.sv
// Top level of the LZSS flag-group decoder: output register and history RAM hookup.
// Depends on lfgd_pkg, lfgd_ram and lfgd_core.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------------
//   in       | sink      | in_valid / in_ready    | in_data  (in_byte, start_of_stream)
//   out      | source    | out_valid / out_ready  | out_data (out_byte, status, last_of_run)
//
// A literal, header or flag byte is handled as it is accepted. A back-reference
// takes its two bytes, the second of which starts the first history read, then
// one copied byte per cycle while the output is not stalled (3 to 18), paced by the
// single read port of the history RAM and its registered read data.
// Reset clears all control state; the history needs no clearing because a
// distance check keeps every read on bytes of the current stream.
// A stalled output holds the result register and the copy sequencer; the input
// is refused while a copy runs or while the result register is full and not taken.
`timescale 1ns / 1ps
module lz77_flag_group_decoder_top #(
	parameter int WINDOW_DEPTH = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lfgd_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output lfgd_pkg::out_t out_data
);

	localparam int AW = $clog2(WINDOW_DEPTH);

	logic            out_valid_q;
	lfgd_pkg::out_t  out_data_q;
	logic            slot_free;
	lfgd_pkg::emit_t emit;
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [7:0]      ram_wdata, ram_rdata;

	// the result register can take a new transaction when empty or being drained
	assign slot_free = !out_valid_q || out_ready;

	lfgd_core #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.slot_free(slot_free),
		.emit     (emit),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	// history window of decoded bytes
	lfgd_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_DEPTH)
	) u_history (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// hold the valid flag: set on a new result, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload needs no reset; load only when the core hands over a result
	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_data_q <= emit.res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: hw/rtl/lfgd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
module lfgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/lfgd_core.sv
// Parser and copy sequencer: header check, flag groups, literals and back-references.
// Uses lfgd_pkg; drives the history RAM ports that the top level connects to lfgd_ram.
`timescale 1ns / 1ps
module lfgd_core #(
	parameter int WINDOW_DEPTH = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  lfgd_pkg::in_t                   in_data,
	input  logic                            slot_free,
	output lfgd_pkg::emit_t                 emit,
	output logic                            ram_we,
	output logic [$clog2(WINDOW_DEPTH)-1:0] ram_waddr,
	output logic [7:0]                      ram_wdata,
	output logic                            ram_re,
	output logic [$clog2(WINDOW_DEPTH)-1:0] ram_raddr,
	input  logic [7:0]                      ram_rdata
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int SW = ((AW > lfgd_pkg::DIST_W) ? AW : lfgd_pkg::DIST_W) + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
	localparam logic [SW-1:0] DEPTH_EXT = SW'(WINDOW_DEPTH);

	typedef enum logic [2:0] {
		S_HEADER,
		S_FLAG,
		S_TOKEN,
		S_REF_LOW,
		S_COPY,
		S_DONE,
		S_ERROR
	} phase_t;

	phase_t      phase_q, phase_n, eff_phase;
	logic [3:0]  hdr_idx_q, hdr_idx_n, eff_idx;
	logic [31:0] size_q, size_n, eff_size, size_v;
	logic [31:0] pc_q, pc_n, pc_inc;
	logic [7:0]  flags_q, flags_n;
	logic [2:0]  tok_q, tok_n;
	logic [7:0]  pend_q, pend_n;
	logic [AW-1:0] wptr_q, wptr_n, wptr_inc;
	logic [AW-1:0] src_q, src_n, src_inc, src0;
	logic [4:0]  remain_q, remain_n, len;
	logic        dist1_q, dist1_n;
	logic [7:0]  last_byte_q, last_byte_n, copy_byte, b;
	logic [lfgd_pkg::DIST_W-1:0] ref_dist;
	logic [SW-1:0] diff;
	logic        accept, is_final, bad_dist;
	lfgd_pkg::emit_t emit_n;

	assign b         = in_data.in_byte;
	assign in_ready  = (phase_q != S_COPY) && slot_free;
	assign accept    = in_valid && in_ready;
	assign eff_phase = in_data.start_of_stream ? S_HEADER : phase_q;
	assign eff_idx   = in_data.start_of_stream ? 4'd0 : hdr_idx_q;
	assign eff_size  = in_data.start_of_stream ? 32'd0 : size_q;

	assign pc_inc   = pc_q + 32'd1;
	assign is_final = (pc_inc == size_q);
	assign wptr_inc = (wptr_q == LAST_ADDR) ? '0 : wptr_q + AW'(1);
	assign src_inc  = (src_q == LAST_ADDR) ? '0 : src_q + AW'(1);

	assign ref_dist = lfgd_pkg::DIST_W'({pend_q[7:4], b}) + lfgd_pkg::DIST_W'(1);
	assign len      = {1'b0, pend_q[3:0]} + lfgd_pkg::MATCH_LEN_BASE;
	assign bad_dist = ({{(32 - lfgd_pkg::DIST_W){1'b0}}, ref_dist} > pc_q)
		|| (SW'(ref_dist) > DEPTH_EXT);
	assign diff     = SW'(wptr_q) - SW'(ref_dist);
	assign src0     = diff[SW-1] ? AW'(diff + DEPTH_EXT) : AW'(diff);
	assign copy_byte = dist1_q ? last_byte_q : ram_rdata;

	always_comb begin
		size_v = eff_size;
		size_v[{eff_idx[1:0], 3'b000} +: 8] = eff_size[{eff_idx[1:0], 3'b000} +: 8] | b;
	end

	always_comb begin
		phase_n     = phase_q;
		hdr_idx_n   = hdr_idx_q;
		size_n      = size_q;
		pc_n        = pc_q;
		flags_n     = flags_q;
		tok_n       = tok_q;
		pend_n      = pend_q;
		wptr_n      = wptr_q;
		src_n       = src_q;
		remain_n    = remain_q;
		dist1_n     = dist1_q;
		last_byte_n = last_byte_q;
		emit_n      = '0;
		ram_we      = 1'b0;
		ram_waddr   = wptr_q;
		ram_wdata   = b;
		ram_re      = 1'b0;
		ram_raddr   = src_q;

		if (accept) begin
			if (in_data.start_of_stream) begin
				phase_n   = S_HEADER;
				hdr_idx_n = '0;
				size_n    = '0;
				pc_n      = '0;
				wptr_n    = '0;
				flags_n   = '0;
				tok_n     = '0;
				pend_n    = '0;
			end
			unique case (eff_phase)
				S_HEADER: begin
					if (eff_idx < lfgd_pkg::SIG_LEN) begin
						if (b != lfgd_pkg::SIG_BYTES[eff_idx[2:0]]) begin
							emit_n.valid           = 1'b1;
							emit_n.res.status      = lfgd_pkg::STAT_BAD_MAGIC;
							emit_n.res.last_of_run = 1'b1;
							phase_n                = S_ERROR;
						end else begin
							hdr_idx_n = eff_idx + 4'd1;
						end
					end else begin
						size_n    = size_v;
						hdr_idx_n = eff_idx + 4'd1;
						if (eff_idx == lfgd_pkg::HDR_LAST) begin
							if (size_v == 32'd0) begin
								emit_n.valid           = 1'b1;
								emit_n.res.status      = lfgd_pkg::STAT_EMPTY;
								emit_n.res.last_of_run = 1'b1;
								phase_n                = S_DONE;
							end else begin
								phase_n = S_FLAG;
								tok_n   = '0;
							end
						end
					end
				end
				S_FLAG: begin
					flags_n = b;
					tok_n   = '0;
					phase_n = S_TOKEN;
				end
				S_TOKEN: begin
					if (flags_q[tok_q]) begin
						pend_n  = b;
						phase_n = S_REF_LOW;
					end else begin
						ram_we                 = 1'b1;
						wptr_n                 = wptr_inc;
						pc_n                   = pc_inc;
						last_byte_n            = b;
						emit_n.valid           = 1'b1;
						emit_n.res.out_byte    = b;
						emit_n.res.status      = is_final ? lfgd_pkg::STAT_FINAL
							: lfgd_pkg::STAT_BYTE;
						emit_n.res.last_of_run = 1'b1;
						if (is_final) begin
							phase_n = S_DONE;
						end else if (tok_q == 3'd7) begin
							tok_n   = '0;
							phase_n = S_FLAG;
						end else begin
							tok_n   = tok_q + 3'd1;
							phase_n = S_TOKEN;
						end
					end
				end
				S_REF_LOW: begin
					if (bad_dist) begin
						emit_n.valid           = 1'b1;
						emit_n.res.status      = lfgd_pkg::STAT_BAD_DIST;
						emit_n.res.last_of_run = 1'b1;
						phase_n                = S_ERROR;
					end else begin
						// start the first history read now; data arrives in S_COPY
						remain_n  = len;
						dist1_n   = (ref_dist == lfgd_pkg::DIST_W'(1));
						src_n     = src0;
						ram_re    = 1'b1;
						ram_raddr = src0;
						phase_n   = S_COPY;
					end
				end
				default: begin
				end
			endcase
		end else if (phase_q == S_COPY && slot_free) begin
			// emit one copied byte; fetch the next source byte behind it
			ram_we                 = 1'b1;
			ram_wdata              = copy_byte;
			wptr_n                 = wptr_inc;
			pc_n                   = pc_inc;
			last_byte_n            = copy_byte;
			remain_n               = remain_q - 5'd1;
			src_n                  = src_inc;
			ram_re                 = 1'b1;
			ram_raddr              = src_inc;
			emit_n.valid           = 1'b1;
			emit_n.res.out_byte    = copy_byte;
			emit_n.res.status      = is_final ? lfgd_pkg::STAT_FINAL : lfgd_pkg::STAT_BYTE;
			emit_n.res.last_of_run = is_final || (remain_q == 5'd1);
			if (is_final) begin
				phase_n = S_DONE;
			end else if (remain_q == 5'd1) begin
				if (tok_q == 3'd7) begin
					tok_n   = '0;
					phase_n = S_FLAG;
				end else begin
					tok_n   = tok_q + 3'd1;
					phase_n = S_TOKEN;
				end
			end
		end
	end

	assign emit = emit_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= S_HEADER;
			hdr_idx_q   <= '0;
			size_q      <= '0;
			pc_q        <= '0;
			flags_q     <= '0;
			tok_q       <= '0;
			pend_q      <= '0;
			wptr_q      <= '0;
			src_q       <= '0;
			remain_q    <= '0;
			dist1_q     <= 1'b0;
			last_byte_q <= '0;
		end else begin
			phase_q     <= phase_n;
			hdr_idx_q   <= hdr_idx_n;
			size_q      <= size_n;
			pc_q        <= pc_n;
			flags_q     <= flags_n;
			tok_q       <= tok_n;
			pend_q      <= pend_n;
			wptr_q      <= wptr_n;
			src_q       <= src_n;
			remain_q    <= remain_n;
			dist1_q     <= dist1_n;
			last_byte_q <= last_byte_n;
		end
	end

endmodule

// File: tb/tb_lz77_flag_group_decoder_top.sv
// Self-checking bench for lz77_flag_group_decoder_top: feeds compressed LZSS streams byte by
// byte and checks every decoded result against an in-bench decoder. Depends on lfgd_pkg and
// the RTL of the block.
`timescale 1ns / 1ps
module tb_lz77_flag_group_decoder_top;

	localparam int WINDOW      = 4096;
	localparam int WIN_AW      = $clog2(WINDOW);
	localparam int IDLE_PCT    = 38;
	localparam int NO_FAULT    = -1;
	localparam int DRAIN_WAIT  = 40;
	localparam int CYCLE_LIMIT = 400000;

	// parse phases of the in-bench decoder
	typedef enum logic [2:0] {
		PARSE_HEADER, PARSE_FLAG, PARSE_TOKEN, PARSE_REF_LO, PARSE_DONE, PARSE_FAIL
	} parse_e;

	// one queued input transaction; drain_first holds it back until all results are in
	typedef struct packed {
		lfgd_pkg::in_t item;
		logic          drain_first;
	} stim_t;

	logic           clk;
	logic           arst_n    = 1'b0;
	logic           in_valid  = 1'b0;
	logic           in_ready;
	lfgd_pkg::in_t  in_data   = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	lfgd_pkg::out_t out_data;

	stim_t          compressed_bytes [$];
	lfgd_pkg::out_t decoded_queue [$];

	int bytes_taken    = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;
	int hold_left      = 0;
	bit hold_used      = 1'b0;
	logic calm;

	// in-bench decoder state
	parse_e      phase     = PARSE_HEADER;
	logic [3:0]  hdr_idx   = '0;
	logic [31:0] size_goal = '0;
	logic [31:0] produced  = '0;
	logic [7:0]  flags_reg = '0;
	logic [2:0]  tok_idx   = '0;
	logic [7:0]  ref_hi    = '0;
	logic [7:0]  window_mem [WINDOW];

	// last result of the current step is held back so its last_of_run can be set
	lfgd_pkg::out_t held_result;
	bit             have_held = 1'b0;

	lz77_flag_group_decoder_top #(
		.WINDOW_DEPTH(WINDOW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// no random idling on either side for a stretch in the middle of the run
	assign calm = (bytes_taken >= 200) && (bytes_taken < 290);

	// ---------------------------------------------------------------- decoder model

	task automatic push_result(input logic [7:0] b, input logic [2:0] st);
		if (have_held)
			decoded_queue.push_back(held_result);
		held_result.out_byte    = b;
		held_result.status      = st;
		held_result.last_of_run = 1'b0;
		have_held = 1'b1;
	endtask

	// write one byte to the history and stop the stream when the size is reached
	task automatic emit_decoded(input logic [7:0] b);
		window_mem[WIN_AW'(produced % WINDOW)] = b;
		produced = produced + 32'd1;
		if (produced == size_goal) begin
			push_result(b, lfgd_pkg::STAT_FINAL);
			phase = PARSE_DONE;
		end else begin
			push_result(b, lfgd_pkg::STAT_BYTE);
		end
	endtask

	task automatic advance_token();
		if (phase != PARSE_DONE) begin
			if (tok_idx == 3'd7) begin
				tok_idx = '0;
				phase   = PARSE_FLAG;
			end else begin
				tok_idx = tok_idx + 3'd1;
				phase   = PARSE_TOKEN;
			end
		end
	endtask

	// decode one accepted byte and queue the results it causes
	task automatic lzss_decode_step(input lfgd_pkg::in_t item);
		logic [7:0]        b;
		logic [12:0]       ref_dist;
		logic [4:0]        len;
		logic [WIN_AW-1:0] src;
		int                i;
		b = item.in_byte;
		if (item.start_of_stream) begin
			phase     = PARSE_HEADER;
			hdr_idx   = '0;
			size_goal = '0;
			produced  = '0;
			flags_reg = '0;
			tok_idx   = '0;
			ref_hi    = '0;
		end
		case (phase)
			PARSE_HEADER: begin
				if (hdr_idx < lfgd_pkg::SIG_LEN) begin
					if (b != lfgd_pkg::SIG_BYTES[hdr_idx[2:0]]) begin
						push_result(8'h00, lfgd_pkg::STAT_BAD_MAGIC);
						phase = PARSE_FAIL;
					end else begin
						hdr_idx = hdr_idx + 4'd1;
					end
				end else begin
					size_goal = size_goal | (32'(b) << (8 * (hdr_idx - lfgd_pkg::SIG_LEN)));
					if (hdr_idx == lfgd_pkg::HDR_LAST) begin
						if (size_goal == 0) begin
							push_result(8'h00, lfgd_pkg::STAT_EMPTY);
							phase = PARSE_DONE;
						end else begin
							phase   = PARSE_FLAG;
							tok_idx = '0;
						end
					end
					hdr_idx = hdr_idx + 4'd1;
				end
			end
			PARSE_FLAG: begin
				flags_reg = b;
				tok_idx   = '0;
				phase     = PARSE_TOKEN;
			end
			PARSE_TOKEN: begin
				if (flags_reg[tok_idx]) begin
					ref_hi = b;
					phase  = PARSE_REF_LO;
				end else begin
					emit_decoded(b);
					advance_token();
				end
			end
			PARSE_REF_LO: begin
				ref_dist = {1'b0, ref_hi[7:4], b} + 13'd1;
				len      = {1'b0, ref_hi[3:0]} + lfgd_pkg::MATCH_LEN_BASE;
				if (ref_dist > produced || ref_dist > WINDOW) begin
					push_result(8'h00, lfgd_pkg::STAT_BAD_DIST);
					phase = PARSE_FAIL;
				end else begin
					// copy may overlap itself; cut short at the stream size
					for (i = 0; i < len && phase != PARSE_DONE; i++) begin
						src = WIN_AW'((produced - 32'(ref_dist)) % WINDOW);
						emit_decoded(window_mem[src]);
					end
					advance_token();
				end
			end
			default: ;
		endcase
		if (have_held) begin
			held_result.last_of_run = 1'b1;
			decoded_queue.push_back(held_result);
			have_held = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------- stream builder

	task automatic queue_byte(input logic [7:0] b, input logic sos, input logic drain);
		stim_t s;
		s.item.in_byte         = b;
		s.item.start_of_stream = sos;
		s.drain_first          = drain;
		compressed_bytes.push_back(s);
	endtask

	task automatic queue_noise(input int n);
		int k;
		for (k = 0; k < n; k++)
			queue_byte(8'($urandom), 1'b0, 1'b0);
	endtask

	// signature then little-endian size; flip one bit at fault_at, stop after keep bytes
	task automatic queue_header(input logic [31:0] goal_size, input int fault_at, input int keep,
			input logic drain);
		logic [7:0] b;
		int k;
		for (k = 0; k < keep; k++) begin
			if (k < 8)
				b = lfgd_pkg::SIG_BYTES[3'(k)];
			else
				b = goal_size[8 * (k - 8) +: 8];
			if (k == fault_at)
				b = b ^ (8'd1 << $urandom_range(7, 0));
			queue_byte(b, k == 0, drain && k == 0);
		end
	endtask

	// flag groups with literals and in-range references; optionally end on a reference
	// that reaches past everything produced so far
	task automatic queue_body(input logic [31:0] goal_size, input int ref_pct,
			input int max_tokens, input bit bad_ref);
		logic [31:0] made;
		int unsigned d, len;
		int          tokens, slot, k;
		logic [7:0]  flags, used;
		logic [11:0] code;
		logic [7:0]  grp [$];
		made   = '0;
		tokens = 0;
		while (made < goal_size && tokens < max_tokens) begin
			flags = '0;
			used  = '0;
			grp.delete();
			for (slot = 0; slot < 8 && made < goal_size && tokens < max_tokens; slot++) begin
				tokens++;
				used[slot] = 1'b1;
				len = $urandom_range(18, 3);
				if (bad_ref && tokens == max_tokens) begin
					flags[slot] = 1'b1;
					d = $urandom_range(4096, made + 1);
				end else if (made != 0 && $urandom_range(99, 0) < ref_pct) begin
					flags[slot] = 1'b1;
					d = $urandom_range((made < 4096) ? made : 4096, 1);
				end
				if (flags[slot]) begin
					code = 12'(d - 1);
					grp.push_back({code[11:8], 4'(len - 3)});
					grp.push_back(code[7:0]);
					made = made + len;
				end else begin
					grp.push_back(8'($urandom));
					made = made + 1;
				end
			end
			// bits past the last token are never looked at; randomize them
			flags = flags | (8'($urandom) & ~used);
			queue_byte(flags, 1'b0, 1'b0);
			for (k = 0; k < grp.size(); k++)
				queue_byte(grp[k], 1'b0, 1'b0);
		end
	endtask

	// ---------------------------------------------------------------- driver

	// Accept and decode on the handshake, then load the next byte unless the
	// current one is still waiting. Idle at random outside the calm stretch and
	// hold a drain-first byte until every result is back.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				lzss_decode_step(in_data);
				bytes_taken++;
			end
			if (!in_valid || in_ready) begin
				if (compressed_bytes.size() != 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT)
						&& (!compressed_bytes[0].drain_first || decoded_queue.size() == 0)) begin
					in_data  <= compressed_bytes[0].item;
					in_valid <= 1'b1;
					void'(compressed_bytes.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// Stall at random; once, hold off for a long stretch so the block backs up
	// into its input while the driver keeps offering bytes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_used && bytes_taken >= 120) begin
				hold_used <= 1'b1;
				hold_left <= 400;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	// Compare each taken result field by field with the oldest prediction.
	always @(posedge clk) begin
		lfgd_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (decoded_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: byte %02h status %0d last %0b",
						out_data.out_byte, out_data.status, out_data.last_of_run);
			end else begin
				want = decoded_queue.pop_front();
				if (out_data.out_byte !== want.out_byte || out_data.status !== want.status
						|| out_data.last_of_run !== want.last_of_run) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: expected byte %02h status %0d last %0b,",
							" got byte %02h status %0d last %0b"},
							want.out_byte, want.status, want.last_of_run,
							out_data.out_byte, out_data.status, out_data.last_of_run);
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	initial begin
		int          kind, fault;
		logic        drain;
		logic [31:0] goal_size;

		// bad signature on the very first byte, then a byte that must be dropped
		queue_byte(8'hFF, 1'b1, 1'b0);
		queue_byte(8'h4C, 1'b0, 1'b0);
		// five-byte stream: literal FF, then a distance-1 length-18 copy cut at the size,
		// then a trailing byte after the end; wait for the bad-signature result first
		queue_header(32'd5, NO_FAULT, 12, 1'b1);
		queue_byte(8'h02, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0);
		queue_byte(8'h0F, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0);
		queue_byte(8'hAA, 1'b0, 1'b0);

		// random streams; most well formed, the rest broken in the ways the
		// decoder must flag, or cut off by the next start
		while (compressed_bytes.size() < 420) begin
			kind  = $urandom_range(99, 0);
			drain = ($urandom_range(9, 0) == 0);
			if (kind < 60) begin
				goal_size = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 41)
					: $urandom_range(40, 1);
				queue_header(goal_size, NO_FAULT, 12, drain);
				queue_body(goal_size, 50, 1 << 30, 1'b0);
				queue_noise($urandom_range(2, 0));
			end else if (kind < 68) begin
				fault = $urandom_range(7, 0);
				queue_header('0, fault, fault + 1, drain);
				queue_noise($urandom_range(3, 0));
			end else if (kind < 74) begin
				queue_header('0, NO_FAULT, 12, drain);
				queue_noise($urandom_range(2, 0));
			end else if (kind < 84) begin
				goal_size = $urandom_range(60, 20);
				queue_header(goal_size, NO_FAULT, 12, drain);
				queue_body(goal_size, 50, $urandom_range(10, 1), 1'b1);
				queue_noise($urandom_range(3, 0));
			end else if (kind < 90) begin
				goal_size = $urandom_range(100, 30);
				queue_header(goal_size, NO_FAULT, 12, drain);
				queue_body(goal_size, 50, $urandom_range(6, 1), 1'b0);
			end else if (kind < 94) begin
				queue_header($urandom, NO_FAULT, $urandom_range(11, 1), drain);
			end else begin
				goal_size = {1'b1, 31'($urandom)};
				queue_header(goal_size, NO_FAULT, 12, drain);
				queue_body(goal_size, 50, $urandom_range(12, 1), 1'b0);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all bytes taken, all results back, then let the pipeline settle
		while (compressed_bytes.size() != 0 || in_valid || decoded_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
